@@ rtl/sorted_key_value_table_macros.svh @@
// Assertion macros used by the sorted key-value table RTL.
`ifndef SORTED_KEY_VALUE_TABLE_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SKVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SKVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/skvt_pkg.sv @@
// Shared types and constants for the sorted key-value table.
package skvt_pkg;

    // Fixed field widths of the stream payloads.
    localparam int IN_KEY_W    = 32;
    localparam int IN_VALUE_W  = 64;
    localparam int IN_TDATA_W  = 96;
    localparam int SLOT_W      = 4;
    localparam int OUT_KEY_W   = 32;
    localparam int OUT_VALUE_W = 64;
    localparam int OUT_TDATA_W = 104;
    localparam int STATUS_W    = 3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 3'd0,
        STATUS_DUPLICATE = 3'd1,
        STATUS_FULL      = 3'd2,
        STATUS_DUMP      = 3'd3,
        STATUS_EMPTY     = 3'd4
    } t_status;

endpackage

@@ rtl/sorted_key_value_table.sv @@
// Sorted key-value table: ascending-key store with insert and ordered dump.
//
// Input stream (s_axis): tuser carries the item kind (insert or dump), tdata
// carries the key and the value word. One item is taken at a time; tready is
// high only while the block waits for a new item.
// Output stream (m_axis): tuser carries the status, tdata the slot, key and
// value, tlast marks the final result of an item. A result sits in an output
// register, so the next item can be taken while that result is still waiting.
//
// Insert: a scan reads one stored key per cycle until it meets a key that is
// not smaller or reaches the last key, then the entries from the insert point
// upward move up one slot per cycle through the single read and single write
// port of the key and value memories. Duplicate and full rejections end after
// the scan.
// Dump: one result per stored entry, one per cycle while the receiver takes
// them, after a registered read; an empty table gives a single result marked
// empty. On a receiver stall the block holds its result and read address.
// Reset clears the entry count and the handshake state; the memories are not
// cleared, since only data from slots below the entry count is ever used.
`include "sorted_key_value_table_macros.svh"

module sorted_key_value_table import skvt_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // kind
    input  logic                   s_axis_tuser,
    // key [31:0], value_word [95:32]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status [2:0]
    output logic [STATUS_W-1:0]    m_axis_tuser,
    // slot [3:0], entry_key [35:4], entry_value [99:36], zero pad [103:100]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PAD_W = OUT_TDATA_W - SLOT_W - OUT_KEY_W - OUT_VALUE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_WRITE,
        ST_EMIT,
        ST_DUMP
    } t_state;

    logic [KEY_BITS-1:0]   r_key_mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_value_mem [CAPACITY];

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_pos;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_value;
    t_status               r_res_status;
    logic [IDX_W-1:0]      r_res_slot;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [SLOT_W-1:0]     r_out_slot;
    logic [OUT_KEY_W-1:0]  r_out_key;
    logic [OUT_VALUE_W-1:0] r_out_value;
    logic                  r_out_last;

    logic [IDX_W-1:0]      w_rd_addr;
    logic                  w_we;
    logic [IDX_W-1:0]      w_wr_addr;
    logic [KEY_BITS-1:0]   w_wr_key;
    logic [VALUE_BITS-1:0] w_wr_value;

    logic                  w_in_xfer;
    logic                  w_out_free;
    logic                  w_hit;
    logic                  w_above;
    logic                  w_at_end;
    logic                  w_full;
    logic                  w_empty;
    logic [IDX_W-1:0]      w_last_idx;
    logic                  w_scan_go_on;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_hit        = (r_rd_key == r_key);
    assign w_above      = (r_rd_key > r_key);
    assign w_last_idx   = IDX_W'(r_count - 1'b1);
    assign w_at_end     = (r_idx == w_last_idx);
    assign w_full       = (r_count == CNT_W'(CAPACITY));
    assign w_empty      = (r_count == '0);
    assign w_scan_go_on = !w_hit && !w_above && !w_at_end;

    // Memory port control.
    always_comb begin
        w_rd_addr  = r_idx;
        w_we       = 1'b0;
        w_wr_addr  = r_idx + 1'b1;
        w_wr_key   = r_rd_key;
        w_wr_value = r_rd_value;
        unique case (r_state)
            ST_IDLE: begin
                w_rd_addr = '0;
            end
            ST_SCAN: begin
                if (w_scan_go_on) begin
                    w_rd_addr = r_idx + 1'b1;
                end else begin
                    // Start the move-up from the top entry.
                    w_rd_addr = w_last_idx;
                end
            end
            ST_SHIFT: begin
                w_we      = 1'b1;
                w_rd_addr = r_idx - 1'b1;
            end
            ST_WRITE: begin
                w_we       = 1'b1;
                w_wr_addr  = r_pos;
                w_wr_key   = r_key;
                w_wr_value = r_value;
            end
            ST_DUMP: begin
                w_rd_addr = w_out_free ? IDX_W'(r_idx + 1'b1) : r_idx;
            end
            ST_EMIT: begin
                w_rd_addr = r_idx;
            end
            default: begin
                w_rd_addr = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_key_mem[w_wr_addr]   <= w_wr_key;
            r_value_mem[w_wr_addr] <= w_wr_value;
        end
        r_rd_key   <= r_key_mem[w_rd_addr];
        r_rd_value <= r_value_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The emitting states load the output register themselves.
            if (m_axis_tready && r_state != ST_EMIT && r_state != ST_DUMP) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_key   <= KEY_BITS'(s_axis_tdata[IN_KEY_W-1:0]);
                        r_value <= VALUE_BITS'(s_axis_tdata[IN_KEY_W+IN_VALUE_W-1:IN_KEY_W]);
                        r_idx   <= '0;
                        r_pos   <= '0;
                        if (s_axis_tuser == KIND_DUMP) begin
                            if (w_empty) begin
                                r_res_status <= STATUS_EMPTY;
                                r_res_slot   <= '0;
                                r_state      <= ST_EMIT;
                            end else begin
                                r_state <= ST_DUMP;
                            end
                        end else if (w_empty) begin
                            r_state <= ST_WRITE;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // Keys are ascending, so a duplicate can only sit at the
                    // first key that is not smaller than the new one.
                    if (w_hit) begin
                        r_res_status <= STATUS_DUPLICATE;
                        r_res_slot   <= r_idx;
                        r_state      <= ST_EMIT;
                    end else if (w_above || w_at_end) begin
                        if (w_full) begin
                            r_res_status <= STATUS_FULL;
                            r_res_slot   <= '0;
                            r_state      <= ST_EMIT;
                        end else if (w_above) begin
                            r_pos   <= r_idx;
                            r_idx   <= w_last_idx;
                            r_state <= ST_SHIFT;
                        end else begin
                            r_pos   <= r_idx + 1'b1;
                            r_state <= ST_WRITE;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_SHIFT: begin
                    if (r_idx == r_pos) begin
                        r_state <= ST_WRITE;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                ST_WRITE: begin
                    r_count      <= r_count + 1'b1;
                    r_res_status <= STATUS_INSERTED;
                    r_res_slot   <= r_pos;
                    r_state      <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_slot   <= SLOT_W'(r_res_slot);
                        r_out_key    <= '0;
                        r_out_value  <= '0;
                        r_out_last   <= 1'b1;
                        r_state      <= ST_IDLE;
                    end
                end
                ST_DUMP: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= STATUS_DUMP;
                        r_out_slot   <= SLOT_W'(r_idx);
                        r_out_key    <= OUT_KEY_W'(r_rd_key);
                        r_out_value  <= OUT_VALUE_W'(r_rd_value);
                        r_out_last   <= w_at_end;
                        if (w_at_end) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {PAD_W'(0), r_out_value, r_out_key, r_out_slot};
    assign m_axis_tlast  = r_out_last;

    `SKVT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `SKVT_ASSERT_NEXT(a_count_grows, r_state == ST_WRITE, r_count == $past(r_count) + 1'b1, "insert did not count")
    `SKVT_ASSERT_NEXT(a_count_held, r_state != ST_WRITE, $stable(r_count), "count moved outside an insert")
    `SKVT_ASSERT_NOW(a_shift_above_pos, r_state == ST_SHIFT, r_idx >= r_pos, "move-up went below the insert slot")
    `SKVT_ASSERT_NOW(a_scan_in_range, r_state == ST_SCAN || r_state == ST_DUMP, r_idx < r_count, "read beyond stored entries")

endmodule
